// File: hw/rtl/bbl_pkg.sv
package bbl_pkg;

   // Pixel geometry: three 8-bit channels, red in lane 0.
   localparam int PIX_W = 8;
   localparam int CH_N = 3;
   localparam int PIX_MAX = (1 << PIX_W) - 1;

   // The quotient is one pixel wide, and the divider resolves one bit per stage.
   localparam int DIV_STAGES = PIX_W;

   // Radius register width and its value after reset.
   localparam int CSR_W = 5;
   localparam int RADIUS_RESET = 31;

   typedef logic [CH_N-1:0][PIX_W-1:0] bbl_pix_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic             line_end;
   } bbl_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic             last_of_line;
   } bbl_rsp_type;

   // Command from the sequencer to the channel lanes.
   typedef struct packed {
      logic clear;
      logic sub;
      logic emit;
      logic last;
   } bbl_cmd_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_STEP,
      SEQ_FLUSH_RD,
      SEQ_FLUSH_UPD
   } bbl_state_type;

endpackage

// File: hw/rtl/bbl_lane.sv
module bbl_lane
   import bbl_pkg::*;
#(
   parameter int MAX_RADIUS = 31,
   localparam int RAD_W = $clog2(MAX_RADIUS + 1)
) (
   input  logic                  clock,
   input  logic                  upd,
   input  logic                  adv,
   input  bbl_cmd_type           cmd,
   input  logic [RAD_W:0]        k,
   input  logic [PIX_W-1:0]      px,
   input  logic [PIX_W-1:0]      leave,
   input  logic [RAD_W:0]        span,
   output logic [PIX_W-1:0]      quo
);

   localparam int WIN_W = RAD_W + 1;
   localparam int SUM_W = $clog2((2 * MAX_RADIUS + 1) * PIX_MAX + 1);
   localparam int PRD_W = PIX_W + WIN_W;

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] drop;
   logic [PRD_W-1:0] prod;

   logic [SUM_W-1:0] rem_ff [DIV_STAGES];
   logic [PIX_W-1:0] quo_ff [1:DIV_STAGES];
   logic [SUM_W-1:0] dvs    [DIV_STAGES];
   logic [SUM_W-1:0] rem_nx [DIV_STAGES-1];
   logic             ge     [DIV_STAGES];

   // Running window sum: optional clear, drop the leaving pixel, add k copies of the new one.
   always_comb begin
      base = cmd.clear ? '0 : sum_ff;
      drop = cmd.sub ? SUM_W'(leave) : '0;
      prod = PRD_W'(px) * PRD_W'(k);
      sum_in = base - drop + SUM_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         sum_ff <= sum_in;
      end
   end

   // Restoring division by the span, one quotient bit per stage, MSB first.
   always_comb begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         dvs[j] = SUM_W'(span) << (DIV_STAGES - 1 - j);
         ge[j] = rem_ff[j] >= dvs[j];
      end
      for (int j = 0; j < DIV_STAGES - 1; j++) begin
         rem_nx[j] = ge[j] ? rem_ff[j] - dvs[j] : rem_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= sum_in;
         quo_ff[1] <= PIX_W'(ge[0]);
         for (int j = 1; j < DIV_STAGES; j++) begin
            rem_ff[j] <= rem_nx[j-1];
            quo_ff[j+1] <= {quo_ff[j][PIX_W-2:0], ge[j]};
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES];

endmodule

// File: hw/rtl/bbl_seq.sv
module bbl_seq
   import bbl_pkg::*;
#(
   parameter int MAX_RADIUS = 31,
   localparam int RAD_W = $clog2(MAX_RADIUS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  bbl_req_type       req_data,
   input  logic              adv,
   output logic              go,
   output bbl_cmd_type       cmd,
   output logic [RAD_W:0]    k,
   output bbl_pix_type       px,
   output bbl_pix_type       leave,
   output logic [RAD_W:0]    span
);

   localparam int WIN_MAX = 2 * MAX_RADIUS + 1;
   localparam int WIN_W = RAD_W + 1;
   localparam int PTR_W = $clog2(WIN_MAX);
   localparam int RAD_RST = (RADIUS_RESET > MAX_RADIUS) ? MAX_RADIUS : RADIUS_RESET;

   bbl_state_type    state_ff, state_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [WIN_W-1:0] n_ff, n_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] last_ptr_ff, last_ptr_in;
   logic [RAD_W-1:0] m_ff, m_in;
   bbl_pix_type      px_ff, px_in;
   logic             end_ff, end_in;
   bbl_pix_type      first_ff, first_in;
   bbl_pix_type      rd_ff;

   bbl_pix_type      mem [WIN_MAX];
   logic             mem_we;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   bbl_pix_type      req_pix;

   logic [WIN_W-1:0] r_w;
   logic [WIN_W-1:0] back;
   logic [WIN_W:0]   fl_sum;
   logic [PTR_W-1:0] fl_addr;
   logic [PTR_W-1:0] ptr_inc;
   logic [WIN_W-1:0] k_base;
   logic [WIN_W-1:0] k_extra;
   logic [RAD_W-1:0] rad_wr;
   logic             n0;
   logic             n_lt_r;

   assign req_pix = bbl_pix_type'({req_data.blue_in, req_data.green_in, req_data.red_in});
   assign px = px_ff;

   // Window geometry and the flush read address, lastpos - (m + r) modulo the span.
   always_comb begin
      r_w = WIN_W'(rad_ff);
      span = {rad_ff, 1'b1};
      n0 = n_ff == '0;
      n_lt_r = n_ff < r_w;
      back = WIN_W'(m_ff) + r_w;
      fl_sum = (WIN_W+1)'(last_ptr_ff) + (WIN_W+1)'(span) - (WIN_W+1)'(back);
      fl_addr = (fl_sum >= (WIN_W+1)'(span)) ? PTR_W'(fl_sum - (WIN_W+1)'(span))
                                             : PTR_W'(fl_sum);
      ptr_inc = (ptr_ff == PTR_W'(span - 1'b1)) ? '0 : ptr_ff + 1'b1;
      k_base = n0 ? r_w + 1'b1 : WIN_W'(1);
      k_extra = (end_ff && n_lt_r) ? r_w - n_ff : '0;
      if (csr_wdata == '0) begin
         rad_wr = RAD_W'(1);
      end else if (32'(csr_wdata) > MAX_RADIUS) begin
         rad_wr = RAD_W'(MAX_RADIUS);
      end else begin
         rad_wr = RAD_W'(csr_wdata);
      end
   end

   // Next state and lane commands.
   always_comb begin
      state_in = state_ff;
      rad_in = rad_ff;
      n_in = n_ff;
      ptr_in = ptr_ff;
      last_ptr_in = last_ptr_ff;
      m_in = m_ff;
      px_in = px_ff;
      end_in = end_ff;
      first_in = first_ff;
      req_ready = 1'b0;
      go = 1'b0;
      cmd = '0;
      k = WIN_W'(1);
      leave = rd_ff;
      mem_we = 1'b0;
      rd_en = 1'b0;
      rd_addr = ptr_ff;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Store the pixel and fetch the slot it replaces in the same cycle.
               mem_we = 1'b1;
               rd_en = 1'b1;
               px_in = req_pix;
               end_in = req_data.line_end;
               last_ptr_in = ptr_ff;
               ptr_in = ptr_inc;
               if (n0) begin
                  first_in = req_pix;
               end
               state_in = SEQ_STEP;
            end
         end
         SEQ_STEP: begin
            leave = (n_ff >= span) ? rd_ff : first_ff;
            cmd.clear = n0;
            cmd.sub = n_ff > r_w;
            cmd.emit = end_ff || !n_lt_r;
            cmd.last = end_ff && n0;
            k = k_base + k_extra;
            if (adv) begin
               go = 1'b1;
               if (!end_ff) begin
                  n_in = (n_ff == WIN_W'(WIN_MAX)) ? n_ff : n_ff + 1'b1;
                  state_in = SEQ_IDLE;
               end else if (n0) begin
                  n_in = '0;
                  ptr_in = '0;
                  state_in = SEQ_IDLE;
               end else begin
                  m_in = n_lt_r ? RAD_W'(n_ff) : rad_ff;
                  state_in = SEQ_FLUSH_RD;
               end
            end
         end
         SEQ_FLUSH_RD: begin
            rd_en = 1'b1;
            rd_addr = fl_addr;
            state_in = SEQ_FLUSH_UPD;
         end
         SEQ_FLUSH_UPD: begin
            // Positions before the line start take the first pixel.
            leave = (n_ff < back) ? first_ff : rd_ff;
            cmd.sub = 1'b1;
            cmd.emit = 1'b1;
            cmd.last = m_ff == RAD_W'(1);
            if (adv) begin
               go = 1'b1;
               m_in = m_ff - 1'b1;
               if (m_ff == RAD_W'(1)) begin
                  n_in = '0;
                  ptr_in = '0;
                  state_in = SEQ_IDLE;
               end else begin
                  state_in = SEQ_FLUSH_RD;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
      // A radius write abandons the line in progress.
      if (csr_we) begin
         rad_in = rad_wr;
         n_in = '0;
         ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         rad_ff <= RAD_W'(RAD_RST);
         n_ff <= '0;
         ptr_ff <= '0;
      end else begin
         state_ff <= state_in;
         rad_ff <= rad_in;
         n_ff <= n_in;
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ptr_ff <= last_ptr_in;
      m_ff <= m_in;
      px_ff <= px_in;
      end_ff <= end_in;
      first_ff <= first_in;
   end

   // Window store: one write and one registered read per cycle, read before write.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ptr_ff] <= req_pix;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/box_blur_line_filter.sv
// Channel  Ports                          Direction  Moves
// req      req_valid/req_ready/req_data   in         one pixel per beat, line_end marks the last
// rsp      rsp_valid/rsp_ready/rsp_data   out        one blurred pixel per beat
// csr      csr_we/csr_wdata               in         radius, written at once, no wait
//
// A pixel is taken in the idle state, which stores it and reads the slot it replaces, and
// the step state updates the running sums before the next pixel is taken. Each flushed
// output at the line end takes a read state and an update state; the store has one read port.
// After its update a result passes the divider stages and then the output register to rsp.
// Reset is synchronous and needs no clearing pass; an unwritten window slot is never used.
// A stall on rsp holds the divider and the sequencer; one more pixel is taken meanwhile.
module box_blur_line_filter
   import bbl_pkg::*;
#(
   parameter int MAX_RADIUS = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bbl_req_type                 req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bbl_rsp_type                 rsp_data,
   input  logic                        csr_we,
   input  logic [CSR_W-1:0]            csr_wdata
);

   localparam int RAD_W = $clog2(MAX_RADIUS + 1);

   logic             adv;
   logic             go;
   bbl_cmd_type      cmd;
   logic [RAD_W:0]   k;
   logic [RAD_W:0]   span;
   bbl_pix_type      px;
   bbl_pix_type      leave;
   logic [PIX_W-1:0] quo [CH_N];

   logic             v_ff [DIV_STAGES+1];
   logic             l_ff [DIV_STAGES+1];
   logic             rsp_valid_ff, rsp_valid_in;
   bbl_rsp_type      rsp_data_ff, rsp_data_in;

   // The whole datapath moves when the output register is free or being emptied.
   assign adv = !rsp_valid_ff || rsp_ready;

   bbl_seq #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .adv(adv),
      .go(go),
      .cmd(cmd),
      .k(k),
      .px(px),
      .leave(leave),
      .span(span)
   );

   // One lane per colour channel.
   for (genvar ch = 0; ch < CH_N; ch++) begin : g_lane
      bbl_lane #(
         .MAX_RADIUS(MAX_RADIUS)
      ) u_lane (
         .clock(clock),
         .upd(go),
         .adv(adv),
         .cmd(cmd),
         .k(k),
         .px(px[ch]),
         .leave(leave[ch]),
         .span(span),
         .quo(quo[ch])
      );
   end

   // Valid and last flags travel beside the lane dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STAGES; j++) begin
            v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= go && cmd.emit;
         for (int j = 1; j <= DIV_STAGES; j++) begin
            v_ff[j] <= v_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_ff[0] <= cmd.last;
         for (int j = 1; j <= DIV_STAGES; j++) begin
            l_ff[j] <= l_ff[j-1];
         end
      end
   end

   // Merge the three lane quotients into one output beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (adv) begin
         rsp_valid_in = v_ff[DIV_STAGES];
         rsp_data_in.red_out = quo[0];
         rsp_data_in.green_out = quo[1];
         rsp_data_in.blue_out = quo[2];
         rsp_data_in.last_of_line = l_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The lanes are only updated while the pipeline moves.
   a_go_adv: assert property (@(posedge clock) disable iff (reset) go |-> adv)
      else $error("lane update while the divider pipeline is held");

   // No lane update while the sequencer is waiting for a pixel.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset) req_ready |-> !go)
      else $error("lane update while idle");

   // After the final output of a line the sequencer takes input again.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (go && cmd.last) |=> req_ready)
      else $error("sequencer not idle after the last output of a line");

endmodule
